// ===== design/kmaa_pkg.sv =====
// Package for the k-means assignment and accumulation block.
// Holds shared widths, item kind codes and a saturation helper; no dependencies.
package kmaa_pkg;

  localparam int unsigned MaxClustersDef = 10;
  localparam int unsigned MaxDimsDef     = 1024;
  localparam int unsigned CoordBitsDef   = 16;

  localparam int unsigned DistBits  = 42;
  localparam int unsigned SumBits   = 36;
  localparam int unsigned CountBits = 20;

  localparam logic [DistBits-1:0]  DistMax  = {DistBits{1'b1}};
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // Item kinds on the command port.
  localparam logic [1:0] KindLoad  = 2'd0;
  localparam logic [1:0] KindPoint = 2'd1;
  localparam logic [1:0] KindRead  = 2'd2;
  localparam logic [1:0] KindClear = 2'd3;

  // Result kinds.
  localparam logic ResAssign = 1'b0;
  localparam logic ResRead   = 1'b1;

  // Configuration register indexes.
  localparam logic RegClusters = 1'b0;
  localparam logic RegDims     = 1'b1;

  // Saturating add of a coordinate into a signed sum.
  function automatic logic [SumBits-1:0] sat_sum(input logic [SumBits-1:0] s,
                                                 input logic [SumBits-1:0] v);
    logic [SumBits:0] t;
    t = {s[SumBits-1], s} + {v[SumBits-1], v};
    if (t[SumBits] != t[SumBits-1]) begin
      sat_sum = t[SumBits] ? {1'b1, {(SumBits-1){1'b0}}} : {1'b0, {(SumBits-1){1'b1}}};
    end else begin
      sat_sum = t[SumBits-1:0];
    end
  endfunction

endpackage

// ===== design/kmaa_dist.sv =====
// Squared distance term and saturating accumulate for one centre.
// A registered difference, then a combinational square-and-add. Uses kmaa_pkg.
module kmaa_dist import kmaa_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [CoordBits-1:0] centre_i,
  input  logic [CoordBits-1:0] point_i,
  input  logic [DistBits-1:0]  base_i,
  output logic [DistBits-1:0]  sum_o
);

  logic [CoordBits:0] diff_q;
  logic [CoordBits:0] diff_d;
  logic [CoordBits:0] mag;
  logic [2*CoordBits+1:0] sq;
  logic [DistBits:0] tot;
  logic [DistBits-1:0] term;

  // Stage one: signed difference.
  assign diff_d = {centre_i[CoordBits-1], centre_i} - {point_i[CoordBits-1], point_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q <= diff_d;
    end
  end

  // Stage two: square, clamp, add.
  assign mag = diff_q[CoordBits] ? (~diff_q + 1'b1) : diff_q;
  assign sq  = mag * mag;

  always_comb begin
    if ((2*CoordBits+2) > DistBits && (sq >> DistBits) != '0) begin
      term = DistMax;
    end else begin
      term = DistBits'(sq);
    end
    tot = {1'b0, base_i} + {1'b0, term};
  end

  assign sum_o = tot[DistBits] ? DistMax : tot[DistBits-1:0];

endmodule

// ===== design/kmaa_core.sv =====
// Sequencer and memories for the assignment pass: centre store, point buffer,
// sums memory, accumulators and counts. Uses kmaa_pkg and kmaa_dist.
module kmaa_core import kmaa_pkg::*; #(
  parameter int unsigned MaxClusters = MaxClustersDef,
  parameter int unsigned MaxDims     = MaxDimsDef,
  parameter int unsigned CoordBits   = CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           kind_i,
  input  logic [3:0]           cluster_index_i,
  input  logic [9:0]           dim_index_i,
  input  logic [CoordBits-1:0] coord_value_i,
  input  logic [3:0]           cluster_count_i,
  input  logic [10:0]          dimension_count_i,
  output logic                 busy_o,
  output logic                 strobe_o,
  output logic                 result_kind_o,
  output logic [3:0]           cluster_o,
  output logic [DistBits-1:0]  distance_o,
  output logic [SumBits-1:0]   sum_value_o,
  output logic [CountBits-1:0] member_count_o
);

  localparam int unsigned CW = (MaxClusters > 1) ? $clog2(MaxClusters) : 1;
  localparam int unsigned DW = (MaxDims > 1) ? $clog2(MaxDims) : 1;
  localparam int unsigned AW = CW + DW;
  // Rows are padded to a power of two so that {cluster, dim} addresses directly.
  localparam int unsigned Depth = MaxClusters * (2 ** DW);
  localparam int unsigned EW = (MaxDims + 1 > 2) ? $clog2(MaxDims + 1) : 1;
  localparam int unsigned MW = (MaxClusters + 1 > 2) ? $clog2(MaxClusters + 1) : 1;

  typedef enum logic [3:0] {
    StInit, StIdle, StDRd, StDSq, StDWr, StArg, StAcRd, StAcWr, StRdRd, StRdOut, StWipe
  } state_e;

  // Memories: centre store, sums (cleared by an epoch mark per entry), point buffer.
  logic [CoordBits-1:0] cmem [Depth];
  logic [SumBits-1:0]   smem [Depth];
  logic [CoordBits-1:0] pmem [MaxDims];
  logic [1:0]           sepoch [Depth];
  logic [DistBits-1:0]  acc_q [MaxClusters];
  logic [CountBits-1:0] cnt_q [MaxClusters];
  logic [1:0]           epoch_q;

  state_e               state_q;
  logic [AW-1:0]        init_q;
  logic [CW-1:0]        c_q;
  logic [DW-1:0]        j_q;
  logic [DW-1:0]        di_q;
  logic [CoordBits-1:0] v_q;
  logic                 first_q;
  logic                 last_q;
  logic [CW-1:0]        best_q;
  logic [DistBits-1:0]  bestd_q;
  logic [3:0]           ci_q;
  logic                 rd_ok_q;
  logic [CoordBits-1:0] crd_q;
  logic [SumBits-1:0]   srd_q;
  logic                 sval_q;
  logic [CoordBits-1:0] prd_q;
  logic [DistBits-1:0]  dsum;
  logic [EW-1:0]        dims;
  logic [MW-1:0]        ncl;
  logic [SumBits-1:0]   sold;

  // Effective register values.
  always_comb begin
    if (dimension_count_i == '0) dims = EW'(1);
    else if (32'(dimension_count_i) > MaxDims) dims = EW'(MaxDims);
    else dims = EW'(dimension_count_i);
    if (cluster_count_i == '0) ncl = MW'(1);
    else if (32'(cluster_count_i) > MaxClusters) ncl = MW'(MaxClusters);
    else ncl = MW'(cluster_count_i);
  end

  kmaa_dist #(.CoordBits(CoordBits)) u_dist (
    .clk_i   (clk_i),
    .en_i    (state_q == StDSq),
    .centre_i(crd_q),
    .point_i (v_q),
    .base_i  (first_q ? '0 : acc_q[c_q]),
    .sum_o   (dsum)
  );

  assign sold   = sval_q ? srd_q : '0;
  assign busy_o = (state_q != StIdle);

  // Memory ports: one read and one write each, read data registered.
  always_ff @(posedge clk_i) begin
    crd_q  <= cmem[{c_q, (state_q == StIdle) ? DW'(dim_index_i) : di_q}];
    srd_q  <= smem[{(state_q == StIdle) ? CW'(cluster_index_i) : best_q,
                    (state_q == StIdle) ? DW'(dim_index_i) : j_q}];
    sval_q <= (sepoch[{(state_q == StIdle) ? CW'(cluster_index_i) : best_q,
                       (state_q == StIdle) ? DW'(dim_index_i) : j_q}] == epoch_q);
    prd_q  <= pmem[j_q];
    if (state_q == StInit) begin
      cmem[init_q]   <= '0;
      sepoch[init_q] <= epoch_q;
      smem[init_q]   <= '0;
    end else if (state_q == StWipe) begin
      sepoch[init_q] <= epoch_q;
      smem[init_q]   <= '0;
    end else if (state_q == StIdle && start_i && kind_i == KindLoad &&
                 32'(cluster_index_i) < MaxClusters && 32'(dim_index_i) < MaxDims) begin
      cmem[{CW'(cluster_index_i), DW'(dim_index_i)}] <= coord_value_i;
    end else if (state_q == StAcWr) begin
      smem[{best_q, j_q}]   <= sat_sum(sold, {{(SumBits-CoordBits){prd_q[CoordBits-1]}},
                                              prd_q});
      sepoch[{best_q, j_q}] <= epoch_q;
    end
    if (state_q == StIdle && start_i && kind_i == KindPoint && 32'(dim_index_i) < 32'(dims)) begin
      pmem[DW'(dim_index_i)] <= coord_value_i;
    end
  end

  // Sequencer with result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StInit;
      init_q         <= '0;
      epoch_q        <= '0;
      c_q            <= '0;
      j_q            <= '0;
      strobe_o       <= 1'b0;
      result_kind_o  <= ResAssign;
      cluster_o      <= '0;
      distance_o     <= '0;
      sum_value_o    <= '0;
      member_count_o <= '0;
      for (int i = 0; i < MaxClusters; i++) begin
        acc_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      strobe_o <= 1'b0;
      case (state_q)
        StInit, StWipe: begin
          init_q <= init_q + 1'b1;
          if (32'(init_q) == Depth - 1) state_q <= StIdle;
        end
        StIdle: begin
          c_q   <= '0;
          di_q  <= DW'(dim_index_i);
          v_q   <= coord_value_i;
          ci_q  <= cluster_index_i;
          rd_ok_q <= 32'(cluster_index_i) < MaxClusters && 32'(dim_index_i) < MaxDims;
          first_q <= (dim_index_i == '0);
          last_q  <= (32'(dim_index_i) == 32'(dims) - 1);
          if (start_i) begin
            case (kind_i)
              KindPoint: if (32'(dim_index_i) < 32'(dims)) state_q <= StDSq;
              KindRead:  state_q <= StRdOut;
              KindClear: begin
                epoch_q <= epoch_q + 1'b1;
                for (int i = 0; i < MaxClusters; i++) cnt_q[i] <= '0;
                // The epoch is about to wrap, so old marks must be rewritten.
                if (&epoch_q) begin
                  init_q  <= '0;
                  state_q <= StWipe;
                end
              end
              default: ;
            endcase
          end
        end
        StDRd: state_q <= StDSq;
        StDSq: state_q <= StDWr;
        StDWr: begin
          acc_q[c_q] <= dsum;
          if (32'(c_q) == MaxClusters - 1) begin
            c_q     <= '0;
            state_q <= last_q ? StArg : StIdle;
            best_q  <= '0;
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= StDRd;
          end
        end
        StArg: begin
          // Walk centres; strictly less keeps the lowest index on ties.
          if (c_q == '0 || acc_q[c_q] < bestd_q) begin
            bestd_q <= acc_q[c_q];
            best_q  <= c_q;
          end
          if (32'(c_q) + 1 >= 32'(ncl)) begin
            c_q     <= '0;
            j_q     <= '0;
            state_q <= StAcRd;
          end else begin
            c_q <= c_q + 1'b1;
          end
        end
        StAcRd: state_q <= StAcWr;
        StAcWr: begin
          if (32'(j_q) + 1 >= 32'(dims)) begin
            if (cnt_q[best_q] != CountMax) cnt_q[best_q] <= cnt_q[best_q] + 1'b1;
            strobe_o       <= 1'b1;
            result_kind_o  <= ResAssign;
            cluster_o      <= 4'(best_q);
            distance_o     <= bestd_q;
            sum_value_o    <= '0;
            member_count_o <= '0;
            state_q        <= StIdle;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= StAcRd;
          end
        end
        StRdRd: state_q <= StRdOut;
        StRdOut: begin
          strobe_o       <= 1'b1;
          result_kind_o  <= ResRead;
          cluster_o      <= ci_q;
          distance_o     <= '0;
          sum_value_o    <= rd_ok_q ? sold : '0;
          member_count_o <= rd_ok_q ? cnt_q[CW'(ci_q)] : '0;
          state_q        <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== design/kmeans_assign_accumulate.sv =====
// k-means assignment pass: each point coordinate runs square and write states
// for every centre slot, with a read state between slots; the last coordinate
// adds an argmin walk over the centres in use and a read and a write state per
// dimension to fold the point into the sums memory. Every fourth clear also
// rewrites that memory, one entry per cycle. After reset a clearing pass over
// MAX_CLUSTERS rows of MAX_DIMS, rounded up to a power of two, holds busy high.
module kmeans_assign_accumulate import kmaa_pkg::*; #(
  parameter int unsigned MAX_CLUSTERS = MaxClustersDef,
  parameter int unsigned MAX_DIMS     = MaxDimsDef,
  parameter int unsigned COORD_BITS   = CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            kind_i,
  input  logic [3:0]            cluster_index_i,
  input  logic [9:0]            dim_index_i,
  input  logic [COORD_BITS-1:0] coord_value_i,
  output logic                  strobe_o,
  output logic                  result_kind_o,
  output logic [3:0]            cluster_o,
  output logic [DistBits-1:0]   distance_o,
  output logic [SumBits-1:0]    sum_value_o,
  output logic [CountBits-1:0]  member_count_o
);

  logic [3:0]  cluster_count_q;
  logic [10:0] dimension_count_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_count_q   <= 4'd10;
      dimension_count_q <= 11'd1024;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegClusters) cluster_count_q <= pwdata[3:0];
      else dimension_count_q <= pwdata[10:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegClusters) ? {28'd0, cluster_count_q}
                                            : {21'd0, dimension_count_q};

  kmaa_core #(
    .MaxClusters(MAX_CLUSTERS), .MaxDims(MAX_DIMS), .CoordBits(COORD_BITS)
  ) u_core (
    .clk_i, .rst_ni, .start_i(start), .kind_i, .cluster_index_i, .dim_index_i,
    .coord_value_i, .cluster_count_i(cluster_count_q),
    .dimension_count_i(dimension_count_q), .busy_o(busy), .strobe_o,
    .result_kind_o, .cluster_o, .distance_o, .sum_value_o, .member_count_o
  );

  // A result never follows directly on an accepted item.
  a_no_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !strobe_o) else $error("result too early");

  // Assignments carry no sum or count.
  a_assign_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && result_kind_o == ResAssign) |-> (sum_value_o == '0 && member_count_o == '0))
    else $error("assignment has stray fields");

  // Readbacks carry no distance.
  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && result_kind_o == ResRead) |-> distance_o == '0)
    else $error("readback has distance");

endmodule
